FILE: rtl/core/rwrc_pkg.sv
// ----------------------------------------------------------------------------
// rwrc_pkg
// Types and constants for the receive window rate controller.
// ----------------------------------------------------------------------------
package rwrc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV,
    ST_SMOOTH,
    ST_EST,
    ST_MUL,
    ST_DECIDE,
    ST_DONE
  } state_t;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_RTT_TICKS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINK_CAP  = 4'd1;

  localparam logic [15:0] RTT_DEFAULT    = 16'd1000;
  localparam logic [16:0] LINK_CAP_RESET = 17'd1000;
  localparam logic [15:0] MIN_WINDOW     = 16'd2;

  // 1500 bytes * 80 * 256
  localparam logic [24:0] WIN_RATE_SCALE = 25'd30720000;

  localparam logic [1:0] PHASE_NONE   = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  localparam int unsigned DIVIDEND_W = 48;
  localparam int unsigned DIVISOR_W  = 32;

endpackage

FILE: rtl/core/receive_window_rate_controller.sv
// ----------------------------------------------------------------------------
// receive_window_rate_controller
// Incast receive window controller driven by slot ticks and rate updates.
// ----------------------------------------------------------------------------
// update request: accepted in idle, then launch, div (48-step serial dividers),
//   smooth, est, mul, decide and done; no new request is taken until idle
// slot tick: accepted in idle, then done; done waits until the result slot is free
// synchronous active-high reset: window 2, rates and counters 0, phase none,
//   rtt 0 (meaning 1000 ticks), link capacity 1000 Mbps
// ----------------------------------------------------------------------------
module receive_window_rate_controller #(
  parameter logic [15:0] MAX_WINDOW = 16'd65535
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [95:0]                         s_tdata,  // now_ticks, flow_bytes, total_bytes
  input  logic                                s_tuser,  // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,  // window, slot_phase, zero pad
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rwrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import rwrc_pkg::*;

  state_t state, state_next;

  logic [15:0] rtt_ticks;
  logic [16:0] link_cap;

  logic [15:0] adv_window;
  logic [31:0] smoothed_rate;
  logic [31:0] last_flow_bytes;
  logic [31:0] last_total_bytes;
  logic [31:0] last_update_time;
  logic [1:0]  phase;

  logic [31:0] now_r, flow_r, total_r;
  logic [31:0] tot_r, wrate_r, est_r, gap_r;
  logic [24:0] avail_r;
  logic [47:0] gapw_r;
  logic [35:0] gap10_r;

  logic        div_start;
  logic        fin_ready;
  logic        accept;
  logic        busy_f, busy_t, busy_w;
  logic [47:0] q_f, q_t, q_w;

  function automatic logic [31:0] sat32(input logic [47:0] q);
    return (q[47:32] != 16'd0) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // request launch
  logic [15:0] rtt_eff;
  logic [31:0] elapsed, span, dflow, dtotal;
  logic [47:0] div_f, div_t, div_w;
  logic [40:0] win_prod;

  assign rtt_eff  = (rtt_ticks == 16'd0) ? RTT_DEFAULT : rtt_ticks;
  assign elapsed  = now_r - last_update_time;
  assign span     = (elapsed == 32'd0 || last_update_time == 32'd0) ? {16'd0, rtt_eff}
                                                                    : elapsed;
  assign dflow    = flow_r - last_flow_bytes;
  assign dtotal   = total_r - last_total_bytes;
  assign div_f    = ({16'd0, dflow} << 14) + ({16'd0, dflow} << 12);
  assign div_t    = ({16'd0, dtotal} << 14) + ({16'd0, dtotal} << 12);
  assign win_prod = 41'(adv_window) * 41'(WIN_RATE_SCALE);
  assign div_w    = {7'd0, win_prod};

  rwrc_div #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div_flow (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_f), .divisor(span),
    .busy(busy_f), .quotient(q_f)
  );

  rwrc_div #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div_total (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_t), .divisor(span),
    .busy(busy_t), .quotient(q_t)
  );

  rwrc_div #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div_window (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_w),
    .divisor({16'd0, rtt_eff}), .busy(busy_w), .quotient(q_w)
  );

  // smoothing
  logic [31:0] msr, tot, wrate, avg, smooth_next;
  logic [34:0] sum7;

  assign msr   = sat32(q_f);
  assign tot   = sat32(q_t);
  assign wrate = sat32(q_w);
  assign sum7  = ({3'd0, smoothed_rate} << 3) - {3'd0, smoothed_rate} + {3'd0, msr};
  assign avg   = sum7[34:3];
  assign smooth_next = (smoothed_rate == 32'd0) ? msr : ((msr > avg) ? msr : avg);

  // estimate and spare capacity
  logic [31:0] est;
  logic [24:0] cap;
  logic [31:0] cap_w;

  assign est   = (smoothed_rate > wrate_r) ? smoothed_rate : wrate_r;
  assign cap   = {link_cap, 8'd0};
  assign cap_w = {7'd0, cap};

  // window decision
  logic        grow_ok, spare, shrink, can_grow;
  logic [28:0] avail10;
  logic [32:0] gap2;
  logic [15:0] window_next;

  assign avail10  = ({4'd0, avail_r} << 3) + ({4'd0, avail_r} << 1);
  assign gap2     = {gap_r, 1'b0};
  assign grow_ok  = (gap10_r <= {4'd0, est_r}) || (gapw_r <= {16'd0, est_r});
  assign spare    = avail10 > {4'd0, cap};
  assign shrink   = gap2 > {1'b0, est_r};
  assign can_grow = (phase == PHASE_SECOND) && spare && (adv_window < MAX_WINDOW);

  always_comb begin
    window_next = adv_window;
    if (est_r != 32'd0) begin
      priority if (grow_ok) begin
        if (can_grow) window_next = adv_window + 16'd1;
      end else if (shrink) begin
        if (adv_window > MIN_WINDOW) window_next = adv_window - 16'd1;
      end else begin
        window_next = adv_window;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = s_tuser ? ST_DONE : ST_LAUNCH;
      ST_LAUNCH: state_next = ST_DIV;
      ST_DIV:    if (!(busy_f || busy_t || busy_w)) state_next = ST_SMOOTH;
      ST_SMOOTH: state_next = ST_EST;
      ST_EST:    state_next = ST_MUL;
      ST_MUL:    state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_DONE;
      ST_DONE:   if (fin_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready  = 1'b1;
      ST_LAUNCH: div_start = 1'b1;
      default: begin
        s_tready  = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  assign accept    = s_tvalid & s_tready;
  assign fin_ready = ~m_tvalid | m_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      rtt_ticks        <= 16'd0;
      link_cap         <= LINK_CAP_RESET;
      adv_window       <= MIN_WINDOW;
      smoothed_rate    <= 32'd0;
      last_flow_bytes  <= 32'd0;
      last_total_bytes <= 32'd0;
      last_update_time <= 32'd0;
      phase            <= PHASE_NONE;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        if (cfg_index == CFG_RTT_TICKS) rtt_ticks <= cfg_data[15:0];
        if (cfg_index == CFG_LINK_CAP)  link_cap  <= cfg_data;
      end

      if (state == ST_DONE && fin_ready) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (accept && s_tuser) begin
        phase <= (phase == PHASE_FIRST) ? PHASE_SECOND : PHASE_FIRST;
      end

      if (state == ST_SMOOTH) smoothed_rate <= smooth_next;

      if (state == ST_DECIDE) begin
        adv_window       <= window_next;
        last_update_time <= now_r;
        last_flow_bytes  <= flow_r;
        last_total_bytes <= total_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r   <= s_tdata[31:0];
      flow_r  <= s_tdata[63:32];
      total_r <= s_tdata[95:64];
    end
    if (state == ST_SMOOTH) begin
      tot_r   <= tot;
      wrate_r <= wrate;
    end
    if (state == ST_EST) begin
      est_r   <= est;
      gap_r   <= est - smoothed_rate;
      avail_r <= (cap_w > tot_r) ? 25'(cap_w - tot_r) : 25'd0;
    end
    if (state == ST_MUL) begin
      gapw_r  <= 48'(gap_r) * 48'(adv_window);
      gap10_r <= ({4'd0, gap_r} << 3) + ({4'd0, gap_r} << 1);
    end
    if (state == ST_DONE && fin_ready) begin
      m_tdata <= {6'd0, phase, adv_window};
    end
  end

endmodule

FILE: rtl/core/rwrc_div.sv
// ----------------------------------------------------------------------------
// rwrc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwrc_div #(
  parameter int unsigned DIVIDEND_W = 48,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] acc;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  take;

  assign trial    = {rem, acc[DIVIDEND_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dsr};
  assign take     = ~diff[DIVISOR_W+1];
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
      acc  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      acc <= {acc[DIVIDEND_W-2:0], take};
      rem <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/rwrc_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrc_test_pkg
// Request codes and the result layout shared by the controller's testbench.
// ----------------------------------------------------------------------------
package rwrc_test_pkg;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic [1:0]  slot_phase;
    logic [15:0] window;
  } window_result_t;

endpackage

FILE: tb/rwrc_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrc_window_checker
// Watches the request, result and register channels of the receive window
// rate controller, predicts the window and slot phase for every accepted
// request and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module rwrc_window_checker #(
  parameter logic [15:0] MAX_WINDOW = 16'd65535
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [95:0]                      s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [23:0]                      m_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rwrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rwrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               pending
);

  import rwrc_pkg::*;
  import rwrc_test_pkg::*;

  // 80 bits per byte-tick scaled to Q24.8
  localparam logic [63:0] BYTE_RATE_SCALE = 64'd20480;

  logic [15:0]    rtt_reg;
  logic [16:0]    cap_reg;
  logic [15:0]    win;
  logic [31:0]    avg_rate;
  logic [31:0]    prev_flow;
  logic [31:0]    prev_total;
  logic [31:0]    prev_time;
  logic [1:0]     slot;
  window_result_t expected_results[$];

  function automatic logic [31:0] mbps_q8(logic [63:0] scaled_bytes, logic [31:0] ticks);
    logic [63:0] q;
    q = scaled_bytes / ((ticks == 32'd0) ? 64'd1 : {32'd0, ticks});
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic void apply_update(logic [31:0] now, logic [31:0] fbytes,
                                       logic [31:0] tbytes);
    logic [31:0] rtt;
    logic [31:0] elapsed;
    logic [31:0] span;
    logic [31:0] flow_rate;
    logic [31:0] total_rate;
    logic [31:0] win_rate;
    logic [31:0] avg;
    logic [31:0] est;
    logic [31:0] cap;
    logic [31:0] avail;
    logic [63:0] gap;
    rtt = (rtt_reg == 16'd0) ? {16'd0, RTT_DEFAULT} : {16'd0, rtt_reg};
    elapsed = now - prev_time;
    span = (elapsed == 32'd0 || prev_time == 32'd0) ? rtt : elapsed;
    flow_rate = mbps_q8({32'd0, fbytes - prev_flow} * BYTE_RATE_SCALE, span);
    total_rate = mbps_q8({32'd0, tbytes - prev_total} * BYTE_RATE_SCALE, span);

    if (avg_rate == 32'd0) begin
      avg_rate = flow_rate;
    end else begin
      avg = 32'((({32'd0, avg_rate} * 64'd7) + {32'd0, flow_rate}) >> 3);
      avg_rate = (flow_rate > avg) ? flow_rate : avg;
    end

    win_rate = mbps_q8({48'd0, win} * {39'd0, WIN_RATE_SCALE}, rtt);
    est = (avg_rate > win_rate) ? avg_rate : win_rate;
    cap = {7'd0, cap_reg, 8'd0};
    avail = (cap > total_rate) ? cap - total_rate : 32'd0;

    if (est != 32'd0) begin
      gap = {32'd0, est - avg_rate};
      if (gap * 10 <= {32'd0, est} || gap * {48'd0, win} <= {32'd0, est}) begin
        if (slot == PHASE_SECOND && {32'd0, avail} * 10 > {32'd0, cap} && win < MAX_WINDOW)
          win = win + 16'd1;
      end else if (gap * 2 > {32'd0, est}) begin
        if (win > MIN_WINDOW) win = win - 16'd1;
      end
    end

    prev_time = now;
    prev_flow = fbytes;
    prev_total = tbytes;
  endfunction

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst) begin
      rtt_reg = 16'd0;
      cap_reg = LINK_CAP_RESET;
      win = MIN_WINDOW;
      avg_rate = 32'd0;
      prev_flow = 32'd0;
      prev_total = 32'd0;
      prev_time = 32'd0;
      slot = PHASE_NONE;
      expected_results.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = window_result_t'(m_tdata[17:0]);
        if (expected_results.size() == 0) begin
          errors++;
          $error("result with no request waiting: window %0d, slot_phase %0d",
                 got.window, got.slot_phase);
        end else begin
          want = expected_results.pop_front();
          if (got.window !== want.window) begin
            errors++;
            $error("window mismatch: expected %0d, got %0d", want.window, got.window);
          end
          if (got.slot_phase !== want.slot_phase) begin
            errors++;
            $error("slot_phase mismatch: expected %0d, got %0d",
                   want.slot_phase, got.slot_phase);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RTT_TICKS: rtt_reg = cfg_data[15:0];
          CFG_LINK_CAP:  cap_reg = cfg_data;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_TICK) begin
          slot = (slot == PHASE_FIRST) ? PHASE_SECOND : PHASE_FIRST;
        end else begin
          apply_update(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
        end
        expected_results.push_back('{slot_phase: slot, window: win});
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/receive_window_rate_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_window_rate_controller_test
// Drives slot ticks and window updates into the receive window rate
// controller under bursty requests and a stalling receiver, across several
// rtt and link capacity settings, while a checker predicts every result.
// ----------------------------------------------------------------------------
module receive_window_rate_controller_test;
  import rwrc_pkg::*;
  import rwrc_test_pkg::*;

  localparam int ITEMS_PER_SETTING = 275;
  localparam int SETTINGS_COUNT    = 6;
  localparam int HOLD_CYCLES       = 600;
  localparam int WATCHDOG_LIMIT    = 4000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [95:0]            s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int errors;
  int pending;

  int          burst_left = 0;
  int          load_segments = 8;
  logic [31:0] clock_ticks = '0;
  logic [31:0] flow_count = '0;
  logic [31:0] total_count = '0;
  int          updates_sent = 0;
  int          ticks_sent = 0;
  int          settings_written = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  logic [15:0] peak_window = '0;

  receive_window_rate_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // now_ticks, flow_bytes, total_bytes
    .s_tuser   (s_tuser),   // op
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // window, slot_phase, zero pad
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rwrc_window_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (m_tdata[15:0] > peak_window) peak_window <= m_tdata[15:0];
    end
  end

  // receiver: random stall patterns, one long hold-off to back the block up
  initial begin
    int run;
    int mode;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_seen >= 400) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 24);
      repeat (run) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic op, input logic [31:0] now,
                           input logic [31:0] flow, input logic [31:0] total);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {total, flow, now};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (op == OP_UPDATE) begin
      clock_ticks = now;
      flow_count = flow;
      total_count = total;
      updates_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic write_config(input logic [15:0] rtt, input logic [16:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RTT_TICKS;
    cfg_data <= {1'b0, rtt};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_LINK_CAP;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // mostly plausible traffic around a drifting flow load, some pure noise
  task automatic send_random(input int unsigned rtt_eff, input int unsigned cap_mbps);
    int unsigned     roll;
    int unsigned     elapsed;
    int unsigned     span;
    int unsigned     frac;
    longint unsigned fdelta;
    longint unsigned tdelta;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      send_tick();
    end else if (roll < 87) begin
      elapsed = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(rtt_eff / 2, rtt_eff * 2);
      span = (elapsed == 0) ? rtt_eff : elapsed;
      if ($urandom_range(0, 5) == 0) begin
        load_segments = $urandom_range(0, 400);
      end else begin
        load_segments = load_segments + int'($urandom_range(0, 4)) - 2;
        if (load_segments < 0) load_segments = 0;
        if (load_segments > 400) load_segments = 400;
      end
      fdelta = (longint'(load_segments) * 1500 * span) / rtt_eff + $urandom_range(0, 1499);
      frac = $urandom_range(0, 120);
      tdelta = fdelta + ((longint'(cap_mbps) * span) / 80) * frac / 100;
      send_item(OP_UPDATE, clock_ticks + elapsed, flow_count + 32'(fdelta),
                total_count + 32'(tdelta));
    end else begin
      send_item(OP_UPDATE, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [15:0] rtt;
    logic [16:0] cap;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_config(16'd0, 17'd1000);

    // first update with no bytes leaves the smoothed rate at zero
    send_item(OP_UPDATE, 32'd0, 32'd0, 32'd0);
    send_item(OP_UPDATE, 32'd1000, 32'd6000, 32'd9000);
    send_tick();
    send_tick();
    send_item(OP_UPDATE, 32'd2000, 32'd12000, 32'd12000);
    // zero elapsed time
    send_item(OP_UPDATE, 32'd2000, 32'd30000, 32'd15000);
    send_tick();
    send_item(OP_UPDATE, 32'd3000, 32'd40000, 32'd16000);
    send_tick();
    // idle flow opens a large gap
    send_item(OP_UPDATE, 32'd4000, 32'd40000, 32'd16000);
    // interface saturated, no spare capacity
    send_item(OP_UPDATE, 32'd4100, 32'd40000, 32'h8000_0000);
    send_item(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // counters and time wrap
    send_item(OP_UPDATE, 32'd0, 32'd0, 32'd0);
    send_item(OP_UPDATE, 32'd0, 32'd0, 32'd0);
    send_item(OP_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_tick();
    send_tick();
    send_tick();
    send_item(OP_UPDATE, 32'h5555_6000, 32'hAAAB_0000, 32'h5555_9000);

    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      case (s)
        0: begin rtt = 16'd1000;  cap = 17'd100000; end
        1: begin rtt = 16'd65535; cap = 17'd131071; end
        2: begin rtt = 16'd1;     cap = 17'd0;      end
        3: begin rtt = 16'd200;   cap = 17'd1;      end
        4: begin
          rtt = 16'($urandom_range(0, 65535));
          cap = 17'($urandom_range(1, 100000));
        end
        default: begin rtt = 16'd5000; cap = 17'd40000; end
      endcase
      drain();
      write_config(rtt, cap);
      repeat (ITEMS_PER_SETTING)
        send_random((rtt == 16'd0) ? 1000 : int'(rtt), int'(cap));
    end

    drain();
    repeat (80) @(posedge clk);

    $display("run covered %0d window updates and %0d slot ticks under %0d register settings",
             updates_sent, ticks_sent, settings_written);
    $display("%0d results compared, largest window seen %0d", results_seen, peak_window);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rwrc_pkg.sv
rtl/core/rwrc_div.sv
rtl/core/receive_window_rate_controller.sv
tb/rwrc_test_pkg.sv
tb/rwrc_window_checker.sv
tb/receive_window_rate_controller_test.sv
